// ===== design/servo_status_packet_parser_assert.svh =====
// assertion macros used by the parser rtl
`ifndef SERVO_STATUS_PACKET_PARSER_ASSERT_SVH
`define SERVO_STATUS_PACKET_PARSER_ASSERT_SVH

// check that holds in the same cycle as the trigger
`define SSPP_ASSERT_NOW(lbl, trig, chk, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (chk)) \
		else $error(msg);

// check that holds in the cycle after the trigger
`define SSPP_ASSERT_NEXT(lbl, trig, chk, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (chk)) \
		else $error(msg);

`endif

// ===== design/sspp_pkg.sv =====
package sspp_pkg;

	localparam int MAX_PARAMS_DEF = 4;
	localparam int PARAM_SLOTS    = 4;
	localparam int BYTE_W         = 8;
	localparam int COUNT_W        = 3;
	localparam int TDATA_IN_W     = 8;
	localparam int TDATA_OUT_W    = 56;

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
	localparam logic [BYTE_W-1:0] LEN_MIN  = 8'd2;

	// phase codes
	localparam logic [2:0] PH_HUNT1 = 3'd0;
	localparam logic [2:0] PH_HUNT2 = 3'd1;
	localparam logic [2:0] PH_ID    = 3'd2;
	localparam logic [2:0] PH_LEN   = 3'd3;
	localparam logic [2:0] PH_ERR   = 3'd4;
	localparam logic [2:0] PH_PARAM = 3'd5;
	localparam logic [2:0] PH_CHECK = 3'd6;

	typedef struct packed {
		logic [PARAM_SLOTS-1:0][BYTE_W-1:0] params;
		logic [COUNT_W-1:0]                 param_count;
		logic [BYTE_W-1:0]                  error_flags;
		logic [BYTE_W-1:0]                  status_id;
	} sspp_result_t;

endpackage

// ===== design/sspp_engine.sv =====
module sspp_engine
	import sspp_pkg::*;
#(
	parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [BYTE_W-1:0]  rx_byte,
	output logic               emit,
	output sspp_result_t       result
);

	localparam logic [BYTE_W-1:0] LEN_MAX = BYTE_W'(MAX_PARAMS + 2);

	logic [2:0]         phase_q, phase_d;
	logic [BYTE_W-1:0]  sum_q, sum_d;
	logic [BYTE_W-1:0]  id_q, id_d;
	logic [BYTE_W-1:0]  err_q, err_d;
	logic [COUNT_W-1:0] exp_q, exp_d;
	logic [COUNT_W-1:0] idx_q, idx_d;
	logic [BYTE_W-1:0]  store_q [MAX_PARAMS];
	logic [PARAM_SLOTS-1:0][BYTE_W-1:0] param_view;

	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		id_d    = id_q;
		err_d   = err_q;
		exp_d   = exp_q;
		idx_d   = idx_q;
		unique case (phase_q)
			PH_HUNT2: begin
				phase_d = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT1;
			end
			PH_ID: begin
				id_d    = rx_byte;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				if (rx_byte >= LEN_MIN && rx_byte <= LEN_MAX) begin
					sum_d   = id_q + rx_byte;
					exp_d   = COUNT_W'(rx_byte - LEN_MIN);
					idx_d   = '0;
					phase_d = PH_ERR;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_ERR: begin
				err_d   = rx_byte;
				sum_d   = sum_q + rx_byte;
				phase_d = (exp_q == '0) ? PH_CHECK : PH_PARAM;
			end
			PH_PARAM: begin
				sum_d = sum_q + rx_byte;
				idx_d = idx_q + 1'b1;
				if (idx_d >= exp_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				phase_d = PH_HUNT1;
			end
			default: begin
				// hunt1 and the unused code
				phase_d = (rx_byte == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			sum_q   <= '0;
			id_q    <= '0;
			err_q   <= '0;
			exp_q   <= '0;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			id_q    <= id_d;
			err_q   <= err_d;
			exp_q   <= exp_d;
			idx_q   <= idx_d;
		end
	end

	// parameter bytes, each entry written only on its own index
	for (genvar i = 0; i < MAX_PARAMS; i++) begin : g_store
		always_ff @(posedge clk) begin
			if (step && phase_q == PH_PARAM && idx_q == COUNT_W'(i)) begin
				store_q[i] <= rx_byte;
			end
		end
	end

	for (genvar i = 0; i < PARAM_SLOTS; i++) begin : g_view
		if (i < MAX_PARAMS) begin : g_used
			assign param_view[i] = (COUNT_W'(i) < exp_q) ? store_q[i] : '0;
		end else begin : g_unused
			assign param_view[i] = '0;
		end
	end

	assign emit = (phase_q == PH_CHECK) && (rx_byte == ~sum_q);

	always_comb begin
		result.status_id   = id_q;
		result.error_flags = err_q;
		result.param_count = exp_q;
		result.params      = param_view;
	end

endmodule

// ===== design/servo_status_packet_parser.sv =====
// channel | dir | tdata fields (lowest bit up)                  | tuser / tlast
// s_*     | in  | rx_byte[7:0]                                  | none
// m_*     | out | status_id, error_flags, param_count,          | none
//         |     | param_0..param_3, zero pad to 56 bits          |
//
// one word per cycle sustained unless stalled; the accepting edge loads the input
// register, and a checksum byte's result word goes on into the output register
// the phase machine and one 8-bit add decide the rate: a single pass per byte
// arst_n clears the phase to header hunting and empties both registers
// a result held in the output register stalls input only when the byte
// in the input register is a passing checksum that needs the output slot
`include "servo_status_packet_parser_assert.svh"

module servo_status_packet_parser
	import sspp_pkg::*;
#(
	parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,   // rx_byte[7:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata    // status_id[7:0], error_flags[15:8],
	                                          // param_count[18:16], param_0[26:19],
	                                          // param_1[34:27], param_2[42:35],
	                                          // param_3[50:43], zeros[55:51]
);

	localparam int PAD_W = TDATA_OUT_W - $bits(sspp_result_t);

	// input register
	logic              v_s1_q;
	logic [BYTE_W-1:0] byte_s1;

	// output register
	logic              out_valid_q;
	sspp_result_t      out_q;

	logic              emit;
	sspp_result_t      result;
	logic              adv;

	// the byte in s1 moves on unless it needs the output slot and that is held
	assign adv      = v_s1_q && (!emit || !out_valid_q || m_tready);
	assign s_tready = !v_s1_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (s_tready) begin
			v_s1_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[BYTE_W-1:0];
		end
	end

	sspp_engine #(
		.MAX_PARAMS (MAX_PARAMS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.emit    (emit),
		.result  (result)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {PAD_W'(0), out_q};

	// input stalls only behind a held result with a checksum byte waiting
	`SSPP_ASSERT_NOW(a_stall_cause, !s_tready, v_s1_q && out_valid_q && !m_tready, "unexpected input stall")
	// a stalled byte must not be overwritten
	`SSPP_ASSERT_NEXT(a_stall_hold, !s_tready, $stable(byte_s1) && v_s1_q, "stalled byte lost")
	// count never exceeds the configured parameter limit
	`SSPP_ASSERT_NOW(a_count_range, out_valid_q, out_q.param_count <= COUNT_W'(MAX_PARAMS), "param_count out of range")
	// absent parameters read as zero
	`SSPP_ASSERT_NOW(a_param_zero, out_valid_q && out_q.param_count == '0, out_q.params == '0, "absent parameter not zero")

endmodule
